### rtl/emc_pkg.sv
// Shared types, constants and date helpers for the elapsed-ms calendar converter.
package emc_pkg;

    localparam int unsigned TS_W     = 32;
    localparam int unsigned TOTAL_W  = 23;
    localparam int unsigned BASE_W   = 17;
    localparam int unsigned DAYS_W   = 6;
    localparam int unsigned TOD_W    = 17;
    localparam int unsigned MT_W     = 11;
    localparam int unsigned DAYSUM_W = 7;

    // floor(n / 1000) = (n * 274877907) >> 38 for any 32-bit n
    localparam logic [31:0] MS_RECIP   = 32'd274877907;
    // floor(y / 675) = (y * 99422) >> 26 for y < 2^16 (total / 86400 with y = total >> 7)
    localparam logic [16:0] DAY_RECIP  = 17'd99422;
    // floor(y / 15) = (y * 34953) >> 19 for y < 2^15 (tod / 60 with y = tod >> 2)
    localparam logic [15:0] MIN_RECIP  = 16'd34953;
    // floor(y / 15) = (y * 547) >> 13 for y < 2^9 (minutes / 60 with y = minutes >> 2)
    localparam logic [9:0]  HOUR_RECIP = 10'd547;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [3:0]  MONTHS        = 4'd12;

    // validity modes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_TIME  = 2'd1;
    localparam logic [1:0] MODE_DATE  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef enum logic [2:0] {
        CFG_HOUR   = 3'd0,
        CFG_MINUTE = 3'd1,
        CFG_SECOND = 3'd2,
        CFG_DAY    = 3'd3,
        CFG_MONTH  = 3'd4,
        CFG_YEAR   = 3'd5,
        CFG_MILLIS = 3'd6,
        CFG_MODE   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [31:0] millis;
        logic [1:0]  mode;
    } ref_cfg_t;

    typedef struct packed {
        logic [11:0]         year;
        logic [3:0]          month;
        logic [DAYSUM_W-1:0] day;
    } date_t;

    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        unique case (month)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // one step of the month walk: roll over if the day exceeds the month
    function automatic date_t date_step(input date_t d);
        date_t      r;
        logic [4:0] len;
        r   = d;
        len = month_len(d.month);
        if (d.day > {2'b00, len}) begin
            r.day = d.day - {2'b00, len};
            if (d.month == MONTHS) begin
                r.month = 4'd1;
                r.year  = d.year + 12'd1;
            end else begin
                r.month = d.month + 4'd1;
            end
        end
        return r;
    endfunction

endpackage

### rtl/elapsed_ms_to_calendar_time.sv
// One item per cycle sustained while the result register is empty or taken.
// The whole pipeline advances together when the result register is empty or taken.
// Stages: tick difference, ms divide multiply, seconds sum, day split, time of day,
// minute and hour splits alongside a three-step month walk.
// Reset (aresetn low, synchronous) empties the pipeline and restores reference registers.
// Top level: configuration registers, pipeline control and result masking.
module elapsed_ms_to_calendar_time
    import emc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_timestamp_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_out_year,
    output logic [3:0]  m_out_month,
    output logic [4:0]  m_out_day,
    output logic [4:0]  m_out_hour,
    output logic [5:0]  m_out_minute,
    output logic [5:0]  m_out_second,
    output logic        m_time_known,
    output logic        m_date_known
);

    ref_cfg_t           cfg_reg;
    ref_cfg_t           cfg_next;
    logic               en;
    logic               secs_vld;
    logic [TOTAL_W-1:0] total;
    logic [DAYS_W-1:0]  days;
    logic               tod_vld;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    date_t              date;
    logic               time_ok;
    logic               date_ok;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HOUR:   cfg_next.hour   = cfg_data[4:0];
                CFG_MINUTE: cfg_next.minute = cfg_data[5:0];
                CFG_SECOND: cfg_next.second = cfg_data[5:0];
                CFG_DAY:    cfg_next.day    = cfg_data[4:0];
                CFG_MONTH:  cfg_next.month  = cfg_data[3:0];
                CFG_YEAR:   cfg_next.year   = cfg_data[11:0];
                CFG_MILLIS: cfg_next.millis = cfg_data;
                CFG_MODE:   cfg_next.mode   = cfg_data[1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hour   <= 5'd0;
            cfg_reg.minute <= 6'd0;
            cfg_reg.second <= 6'd0;
            cfg_reg.day    <= 5'd1;
            cfg_reg.month  <= 4'd1;
            cfg_reg.year   <= 12'd2000;
            cfg_reg.millis <= 32'd0;
            cfg_reg.mode   <= MODE_NONE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    emc_secs u_secs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_valid),
        .ts      (s_timestamp_ms),
        .cfg     (cfg_reg),
        .out_vld (secs_vld),
        .total   (total)
    );

    emc_tod u_tod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (secs_vld),
        .total   (total),
        .days    (days),
        .out_vld (tod_vld),
        .hour    (hour),
        .minute  (minute),
        .second  (second)
    );

    emc_date u_date (
        .aclk (aclk),
        .en   (en),
        .days (days),
        .cfg  (cfg_reg),
        .date (date)
    );

    assign time_ok = cfg_reg.mode != MODE_NONE;
    assign date_ok = cfg_reg.mode[1];

    assign m_valid      = tod_vld;
    assign m_time_known = time_ok;
    assign m_date_known = date_ok;
    assign m_out_hour   = time_ok ? hour   : 5'd0;
    assign m_out_minute = time_ok ? minute : 6'd0;
    assign m_out_second = time_ok ? second : 6'd0;
    assign m_out_year   = date_ok ? date.year        : 12'd0;
    assign m_out_month  = date_ok ? date.month       : 4'd0;
    assign m_out_day    = date_ok ? date.day[4:0]    : 5'd0;

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_hour < 5'd24) && (m_out_minute < 6'd60) && (m_out_second < 6'd60))
        else $error("time field out of range");

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_date_known) |-> (m_out_month >= 4'd1) && (m_out_month <= MONTHS))
        else $error("month out of range");

    a_date_implies_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_date_known |-> m_time_known)
        else $error("date known without time");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_out_hour) && $stable(m_out_second))
        else $error("result lost during stall");

endmodule

### rtl/emc_secs.sv
// Elapsed seconds stages: tick difference, divide by 1000, add reference time of day.
module emc_secs
    import emc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_vld,
    input  logic [TS_W-1:0]    ts,
    input  ref_cfg_t           cfg,
    output logic               out_vld,
    output logic [TOTAL_W-1:0] total
);

    logic [2:0]          vld_reg;
    logic [TS_W-1:0]     elapsed_reg;
    logic [TOTAL_W-1:0]  secs_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [63:0]         prod;
    logic [BASE_W-1:0]   base;

    assign prod = 64'(elapsed_reg) * 64'(MS_RECIP);
    assign base = BASE_W'(cfg.hour) * SECS_PER_HOUR + BASE_W'(cfg.minute) * SECS_PER_MIN
                + BASE_W'(cfg.second);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            elapsed_reg <= ts - cfg.millis;
            secs_reg    <= prod[60:38];
            total_reg   <= TOTAL_W'(base) + secs_reg;
        end
    end

    assign out_vld = vld_reg[2];
    assign total   = total_reg;

endmodule

### rtl/emc_tod.sv
// Day split and hour/minute/second stages by reciprocal multiplies.
module emc_tod
    import emc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_vld,
    input  logic [TOTAL_W-1:0] total,
    output logic [DAYS_W-1:0]  days,
    output logic               out_vld,
    output logic [4:0]         hour,
    output logic [5:0]         minute,
    output logic [5:0]         second
);

    logic [4:0]          vld_reg;
    logic [DAYS_W-1:0]   days_reg;
    logic [TOTAL_W-1:0]  total4_reg;
    logic [TOD_W-1:0]    tod5_reg;
    logic [TOD_W-1:0]    tod6_reg;
    logic [MT_W-1:0]     mt6_reg;
    logic [MT_W-1:0]     mt7_reg;
    logic [5:0]          sec7_reg;
    logic [4:0]          hour7_reg;
    logic [5:0]          sec8_reg;
    logic [4:0]          hour8_reg;
    logic [5:0]          min8_reg;
    logic [32:0]         day_prod;
    logic [TOTAL_W-1:0]  tod_full;
    logic [30:0]         mt_prod;
    logic [TOD_W-1:0]    sec_full;
    logic [18:0]         hour_prod;
    logic [MT_W-1:0]     min_full;

    assign day_prod  = 33'(total[22:7]) * 33'(DAY_RECIP);
    assign tod_full  = total4_reg - TOTAL_W'(days_reg) * TOTAL_W'(SECS_PER_DAY);
    assign mt_prod   = 31'(tod5_reg[16:2]) * 31'(MIN_RECIP);
    assign sec_full  = tod6_reg - TOD_W'(mt6_reg) * SECS_PER_MIN;
    assign hour_prod = 19'(mt6_reg[10:2]) * 19'(HOUR_RECIP);
    assign min_full  = mt7_reg - MT_W'(hour7_reg) * MT_W'(SECS_PER_MIN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            days_reg   <= day_prod[31:26];
            total4_reg <= total;
            tod5_reg   <= tod_full[TOD_W-1:0];
            mt6_reg    <= mt_prod[29:19];
            tod6_reg   <= tod5_reg;
            sec7_reg   <= sec_full[5:0];
            hour7_reg  <= hour_prod[17:13];
            mt7_reg    <= mt6_reg;
            sec8_reg   <= sec7_reg;
            hour8_reg  <= hour7_reg;
            min8_reg   <= min_full[5:0];
        end
    end

    assign days    = days_reg;
    assign out_vld = vld_reg[4];
    assign hour    = hour8_reg;
    assign minute  = min8_reg;
    assign second  = sec8_reg;

endmodule

### rtl/emc_date.sv
// Date stages: add carried days to the reference date and walk month lengths.
module emc_date
    import emc_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [DAYS_W-1:0] days,
    input  ref_cfg_t          cfg,
    output date_t             date
);

    date_t      start_reg;
    date_t      step_reg [3];
    logic [3:0] month_clamp;

    always_comb begin
        priority if (cfg.month == 4'd0) begin
            month_clamp = 4'd1;
        end else if (cfg.month > MONTHS) begin
            month_clamp = MONTHS;
        end else begin
            month_clamp = cfg.month;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            start_reg.year  <= cfg.year;
            start_reg.month <= month_clamp;
            start_reg.day   <= DAYSUM_W'(cfg.day) + DAYSUM_W'(days);
            step_reg[0]     <= date_step(start_reg);
            step_reg[1]     <= date_step(step_reg[0]);
            step_reg[2]     <= date_step(step_reg[1]);
        end
    end

    assign date = step_reg[2];

endmodule
